### src/wss_pkg.sv
// Shared types, constants and arithmetic helpers for the windowed sample statistics block.
package wss_pkg;

   localparam int          DEF_MAX_BINS     = 16;
   localparam logic [31:0] DEF_INTERVAL_US  = 32'd1000000;
   localparam logic [4:0]  DEF_BIN_COUNT    = 5'd16;
   localparam logic [19:0] US_PER_SECOND    = 20'd1000000;
   localparam logic [47:0] CNT48_MAX        = 48'hFFFF_FFFF_FFFF;
   localparam logic signed [15:0] MIN_SENTINEL = 16'sh7FFF;
   localparam logic signed [15:0] MAX_SENTINEL = 16'sh8000;
   localparam int          CSR_ADDR_W       = 4;
   localparam int          RSP_DATA_W       = 384;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_CALC  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      REG_INTERVAL  = 2'd0,
      REG_BIN_COUNT = 2'd1,
      REG_ENABLE    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      SEL_AVG = 2'd0,
      SEL_E2  = 2'd1,
      SEL_SR  = 2'd2,
      SEL_VR  = 2'd3
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DECIDE,
      ST_FOLD,
      ST_LOAD_LIFE,
      ST_LOAD_REC,
      ST_ACC,
      ST_CALC_GO,
      ST_DIV_AVG,
      ST_DIV_E2,
      ST_SQUARE,
      ST_SQRT_GO,
      ST_SQRT,
      ST_DIV_SR,
      ST_DIV_VR,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_MUL,
      DV_NORM,
      DV_RUN
   } div_state_type;

   typedef struct packed {
      logic        add;
      logic        clear;
      logic        latch_t;
      logic        check;
      logic        fold;
      logic        ld_life;
      logic        ld_rec;
      logic        acc_step;
      logic        div_start;
      div_sel_type div_sel;
      logic        cap_a;
      logic        cap_e2;
      logic        cap_m2;
      logic        sqrt_start;
      logic        cap_sr;
      logic        emit_load;
      logic        emit_kind;
   } cmd_type;

   typedef struct packed {
      logic enable;
      logic fire;
      logic rec_last;
      logic div_done;
      logic sqrt_done;
      logic out_free;
   } status_type;

   function automatic logic [63:0] sat_add_s64(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         s = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return s;
   endfunction

   function automatic logic [63:0] sat_add_u64(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [47:0] sat_add_u48(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? CNT48_MAX : s[47:0];
   endfunction

   function automatic logic [31:0] signed_mag32(logic neg, logic [63:0] mag);
      logic [63:0] m;
      if (neg) begin
         m = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
         m = 64'd0 - m;
      end else begin
         m = (mag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : mag;
      end
      return m[31:0];
   endfunction

   function automatic logic [63:0] signed_mag64(logic neg, logic [63:0] mag);
      logic [63:0] m;
      if (neg) begin
         m = (mag > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : mag;
         m = 64'd0 - m;
      end else begin
         m = (mag > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : mag;
      end
      return m;
   endfunction

endpackage

### src/wss_div.sv
// Iterative scaled divider: floor(num * mul * 2^shift / den), saturating at 64 bits.
module wss_div import wss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic        mul_us,
   input  logic        shift32,
   input  logic [63:0] den,
   output logic        busy,
   output logic        done,
   output logic [63:0] quot
);

   div_state_type state_ff, state_in;
   logic [127:0]  acc_ff;
   logic [127:0]  mcand_ff;
   logic [19:0]   mbits_ff;
   logic          sh32_ff;
   logic [63:0]   den_ff;
   logic [63:0]   rem_ff;
   logic [63:0]   lo_ff;
   logic [63:0]   q_ff;
   logic [5:0]    cnt_ff;
   logic          done_ff, done_in;

   logic [127:0]  dvd;
   logic          sat;
   logic [64:0]   rem2;
   logic [64:0]   rem_diff;
   logic          ge;

   assign dvd      = sh32_ff ? (acc_ff << 32) : (acc_ff << 16);
   assign sat      = dvd[127:64] >= den_ff;
   assign rem2     = {rem_ff, lo_ff[63]};
   assign rem_diff = rem2 - {1'b0, den_ff};
   assign ge       = rem2 >= {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         DV_IDLE: begin
            if (start) state_in = DV_MUL;
         end
         DV_MUL: begin
            if (mbits_ff[19:1] == '0) state_in = DV_NORM;
         end
         DV_NORM: begin
            if (sat) begin
               state_in = DV_IDLE;
               done_in  = 1'b1;
            end else begin
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            if (cnt_ff == '1) begin
               state_in = DV_IDLE;
               done_in  = 1'b1;
            end
         end
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         DV_IDLE: begin
            if (start) begin
               acc_ff   <= '0;
               mcand_ff <= {64'd0, num};
               mbits_ff <= mul_us ? US_PER_SECOND : 20'd1;
               sh32_ff  <= shift32;
               den_ff   <= den;
            end
         end
         DV_MUL: begin
            if (mbits_ff[0]) acc_ff <= acc_ff + mcand_ff;
            mcand_ff <= mcand_ff << 1;
            mbits_ff <= mbits_ff >> 1;
         end
         DV_NORM: begin
            rem_ff <= dvd[127:64];
            lo_ff  <= dvd[63:0];
            cnt_ff <= '0;
            if (sat) q_ff <= '1;
         end
         DV_RUN: begin
            rem_ff <= ge ? rem_diff[63:0] : rem2[63:0];
            lo_ff  <= lo_ff << 1;
            q_ff   <= {q_ff[62:0], ge};
            cnt_ff <= cnt_ff + 6'd1;
         end
         default: ;
      endcase
   end

   assign busy = state_ff != DV_IDLE;
   assign done = done_ff;
   assign quot = q_ff;

endmodule

### src/wss_sqrt.sv
// Iterative integer square root, two bits of the radicand per cycle.
module wss_sqrt import wss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff;
   logic        done_ff;
   logic [63:0] v_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] trial;
   logic        ge;

   assign trial = res_ff + bit_ff;
   assign ge    = v_ff >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && cnt_ff == '1;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (cnt_ff == '1) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= value;
         res_ff <= '0;
         bit_ff <= 64'h4000_0000_0000_0000;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         if (ge) begin
            v_ff   <= v_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
         cnt_ff <= cnt_ff + 5'd1;
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

### src/wss_dp.sv
// Datapath: working, lifetime and bin state, result arithmetic and the result register.
module wss_dp import wss_pkg::*; #(
   parameter int MAX_BINS = DEF_MAX_BINS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            st,
   input  logic signed [15:0]    sample_value,
   input  logic [47:0]           timestamp_us,
   input  logic [31:0]           calc_interval_us,
   input  logic [4:0]            bin_count,
   input  logic                  enable,
   input  logic                  cfg_clear,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int PTR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int NB_W  = $clog2(MAX_BINS + 1);

   logic [31:0]        work_cnt_ff;
   logic [63:0]        work_sum_ff;
   logic [63:0]        work_sq_ff;
   logic signed [15:0] work_min_ff;
   logic signed [15:0] work_max_ff;
   logic signed [15:0] work_last_ff;
   logic [47:0]        start_ff;
   logic               started_ff;
   logic [47:0]        t_ff;
   logic [48:0]        diff_ff;

   logic [31:0]        bcnt_ff [MAX_BINS];
   logic [63:0]        bsum_ff [MAX_BINS];
   logic [63:0]        bsq_ff  [MAX_BINS];
   logic signed [15:0] bmin_ff [MAX_BINS];
   logic signed [15:0] bmax_ff [MAX_BINS];
   logic [47:0]        bdur_ff [MAX_BINS];
   logic [MAX_BINS-1:0] bvalid_ff;
   logic [PTR_W-1:0]   ptr_ff;
   logic [PTR_W-1:0]   idx_ff;

   logic [47:0]        tot_cnt_ff;
   logic [63:0]        tot_sum_ff;
   logic [63:0]        tot_sq_ff;
   logic signed [15:0] tot_min_ff;
   logic signed [15:0] tot_max_ff;
   logic [47:0]        tot_dur_ff;

   logic [47:0]        cur_cnt_ff;
   logic [63:0]        cur_sum_ff;
   logic [63:0]        cur_sq_ff;
   logic signed [15:0] cur_min_ff;
   logic signed [15:0] cur_max_ff;
   logic [47:0]        cur_dur_ff;
   logic signed [15:0] last_cap_ff;

   logic [63:0]        a_ff;
   logic [63:0]        e2_ff;
   logic [63:0]        m2_ff;
   logic [63:0]        sr_ff;

   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [NB_W-1:0]    nb;
   logic [PTR_W-1:0]   p;
   logic [PTR_W-1:0]   p_next;
   logic               clear_all;
   logic signed [31:0] sq_prod;
   logic [47:0]        dur;

   logic [31:0]        rd_cnt;
   logic [63:0]        rd_sum;
   logic [63:0]        rd_sq;
   logic signed [15:0] rd_min;
   logic signed [15:0] rd_max;
   logic [47:0]        rd_dur;

   logic               neg;
   logic [63:0]        mag;
   logic               cnt_zero;
   logic               dur_zero;
   logic [31:0]        m;
   logic [63:0]        sqrt_in;
   logic [31:0]        sqrt_root;
   logic               sqrt_done;

   logic [63:0]        div_num;
   logic               div_mul;
   logic               div_sh32;
   logic [63:0]        div_den;
   logic               div_busy;
   logic               div_done;
   logic [63:0]        div_q;

   logic [31:0]        avg_v;
   logic [31:0]        rms_v;
   logic [47:0]        sr_v;
   logic [63:0]        vr_v;

   always_comb begin
      if (bin_count == '0) begin
         nb = NB_W'(1);
      end else if (32'(bin_count) > MAX_BINS) begin
         nb = NB_W'(MAX_BINS);
      end else begin
         nb = NB_W'(bin_count);
      end
   end

   assign p         = (32'(ptr_ff) < 32'(nb)) ? ptr_ff : '0;
   assign p_next    = (32'(p) + 32'd1 >= 32'(nb)) ? '0 : PTR_W'(32'(p) + 32'd1);
   assign clear_all = cmd.clear | cfg_clear;
   assign sq_prod   = sample_value * sample_value;
   assign dur       = diff_ff[47:0];

   assign rd_cnt = bvalid_ff[idx_ff] ? bcnt_ff[idx_ff] : '0;
   assign rd_sum = bvalid_ff[idx_ff] ? bsum_ff[idx_ff] : '0;
   assign rd_sq  = bvalid_ff[idx_ff] ? bsq_ff[idx_ff]  : '0;
   assign rd_min = bvalid_ff[idx_ff] ? bmin_ff[idx_ff] : MIN_SENTINEL;
   assign rd_max = bvalid_ff[idx_ff] ? bmax_ff[idx_ff] : MAX_SENTINEL;
   assign rd_dur = bvalid_ff[idx_ff] ? bdur_ff[idx_ff] : '0;

   assign neg      = cur_sum_ff[63];
   assign mag      = neg ? (64'd0 - cur_sum_ff) : cur_sum_ff;
   assign cnt_zero = cur_cnt_ff == '0;
   assign dur_zero = cur_dur_ff == '0;
   assign m        = (a_ff > 64'hFFFF_FFFF) ? '1 : a_ff[31:0];
   assign sqrt_in  = (e2_ff > m2_ff) ? (e2_ff - m2_ff) : '0;

   always_comb begin
      div_num  = mag;
      div_mul  = 1'b0;
      div_sh32 = 1'b0;
      div_den  = {16'd0, cur_cnt_ff};
      case (cmd.div_sel)
         SEL_AVG: ;
         SEL_E2: begin
            div_num  = cur_sq_ff;
            div_sh32 = 1'b1;
         end
         SEL_SR: begin
            div_num = {16'd0, cur_cnt_ff};
            div_mul = 1'b1;
            div_den = {16'd0, cur_dur_ff};
         end
         SEL_VR: begin
            div_mul = 1'b1;
            div_den = {16'd0, cur_dur_ff};
         end
         default: ;
      endcase
   end

   wss_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .num     (div_num),
      .mul_us  (div_mul),
      .shift32 (div_sh32),
      .den     (div_den),
      .busy    (div_busy),
      .done    (div_done),
      .quot    (div_q)
   );

   wss_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .value (sqrt_in),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   // state that the model clears
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         work_cnt_ff  <= '0;
         work_sum_ff  <= '0;
         work_sq_ff   <= '0;
         work_min_ff  <= MIN_SENTINEL;
         work_max_ff  <= MAX_SENTINEL;
         work_last_ff <= '0;
         started_ff   <= 1'b0;
         bvalid_ff    <= '0;
         ptr_ff       <= '0;
         tot_cnt_ff   <= '0;
         tot_sum_ff   <= '0;
         tot_sq_ff    <= '0;
         tot_min_ff   <= MIN_SENTINEL;
         tot_max_ff   <= MAX_SENTINEL;
         tot_dur_ff   <= '0;
      end else if (cmd.add) begin
         if (!started_ff) begin
            start_ff   <= timestamp_us;
            started_ff <= 1'b1;
         end
         if (work_cnt_ff != '1) work_cnt_ff <= work_cnt_ff + 32'd1;
         work_sum_ff <= sat_add_s64(work_sum_ff, 64'(sample_value));
         work_sq_ff  <= sat_add_u64(work_sq_ff, {32'd0, sq_prod});
         if (sample_value < work_min_ff) work_min_ff <= sample_value;
         if (sample_value > work_max_ff) work_max_ff <= sample_value;
         work_last_ff <= sample_value;
      end else if (cmd.fold) begin
         tot_cnt_ff <= sat_add_u48(tot_cnt_ff, {16'd0, work_cnt_ff});
         tot_sum_ff <= sat_add_s64(tot_sum_ff, work_sum_ff);
         tot_sq_ff  <= sat_add_u64(tot_sq_ff, work_sq_ff);
         if (work_min_ff < tot_min_ff) tot_min_ff <= work_min_ff;
         if (work_max_ff > tot_max_ff) tot_max_ff <= work_max_ff;
         tot_dur_ff <= sat_add_u48(tot_dur_ff, dur);
         bvalid_ff[p] <= 1'b1;
         ptr_ff       <= p_next;
         start_ff     <= t_ff;
         work_cnt_ff  <= '0;
         work_sum_ff  <= '0;
         work_sq_ff   <= '0;
         work_min_ff  <= MIN_SENTINEL;
         work_max_ff  <= MAX_SENTINEL;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fold) begin
         bcnt_ff[p]  <= work_cnt_ff;
         bsum_ff[p]  <= work_sum_ff;
         bsq_ff[p]   <= work_sq_ff;
         bmin_ff[p]  <= work_min_ff;
         bmax_ff[p]  <= work_max_ff;
         bdur_ff[p]  <= dur;
         last_cap_ff <= work_last_ff;
      end
      if (cmd.latch_t) t_ff <= timestamp_us;
      if (cmd.check) diff_ff <= {1'b0, t_ff} - {1'b0, start_ff};
      if (cmd.ld_life) begin
         cur_cnt_ff <= tot_cnt_ff;
         cur_sum_ff <= tot_sum_ff;
         cur_sq_ff  <= tot_sq_ff;
         cur_min_ff <= tot_min_ff;
         cur_max_ff <= tot_max_ff;
         cur_dur_ff <= tot_dur_ff;
      end else if (cmd.ld_rec) begin
         cur_cnt_ff <= '0;
         cur_sum_ff <= '0;
         cur_sq_ff  <= '0;
         cur_min_ff <= MIN_SENTINEL;
         cur_max_ff <= MAX_SENTINEL;
         cur_dur_ff <= '0;
         idx_ff     <= '0;
      end else if (cmd.acc_step) begin
         cur_cnt_ff <= sat_add_u48(cur_cnt_ff, {16'd0, rd_cnt});
         cur_sum_ff <= sat_add_s64(cur_sum_ff, rd_sum);
         cur_sq_ff  <= sat_add_u64(cur_sq_ff, rd_sq);
         if (rd_min < cur_min_ff) cur_min_ff <= rd_min;
         if (rd_max > cur_max_ff) cur_max_ff <= rd_max;
         cur_dur_ff <= sat_add_u48(cur_dur_ff, rd_dur);
         idx_ff     <= idx_ff + 1'b1;
      end
      if (cmd.cap_a)  a_ff  <= div_q;
      if (cmd.cap_e2) e2_ff <= div_q;
      if (cmd.cap_m2) m2_ff <= {32'd0, m} * {32'd0, m};
      if (cmd.cap_sr) sr_ff <= div_q;
   end

   assign avg_v = cnt_zero ? '0 : signed_mag32(neg, a_ff);
   assign rms_v = cnt_zero ? '0 : sqrt_root;
   assign sr_v  = dur_zero ? '0 : ((sr_ff > {16'd0, CNT48_MAX}) ? CNT48_MAX : sr_ff[47:0]);
   assign vr_v  = dur_zero ? '0 : signed_mag64(neg, div_q);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_kind_ff <= cmd.emit_kind;
         rsp_data_ff <= {last_cap_ff, cur_dur_ff, vr_v, sr_v, rms_v, avg_v,
                         cur_max_ff, cur_min_ff, cur_sum_ff, cur_cnt_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign st.enable    = enable;
   assign st.fire      = started_ff && !diff_ff[48] && dur >= {16'd0, calc_interval_us};
   assign st.rec_last  = 32'(idx_ff) + 32'd1 >= 32'(nb);
   assign st.div_done  = div_done;
   assign st.sqrt_done = sqrt_done;
   assign st.out_free  = !rsp_valid_ff || rsp_tready;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a pending item");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider started while busy");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      cmd.fold |=> (32'(ptr_ff) < 32'(nb)))
      else $error("bin pointer beyond window");

   a_fold_started: assert property (@(posedge clock) disable iff (reset)
      cmd.fold |-> started_ff)
      else $error("fold before start");

endmodule

### src/wss_ctrl.sv
// Controller: sequences sample updates, calculation fold, bin sweep and result arithmetic.
module wss_ctrl import wss_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_op,
   input  status_type st,
   output cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rec_ff, rec_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rec_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rec_ff   <= rec_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      rec_in        = rec_ff;
      cmd           = '0;
      cmd.div_sel   = SEL_AVG;
      cmd.emit_kind = rec_ff;
      req_tready    = state_ff == ST_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_op)
                  OP_ADD:   cmd.add = st.enable;
                  OP_CLEAR: cmd.clear = 1'b1;
                  OP_CALC: begin
                     if (st.enable) begin
                        cmd.latch_t = 1'b1;
                        state_in    = ST_CHECK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = st.fire ? ST_FOLD : ST_IDLE;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            rec_in   = 1'b0;
            state_in = ST_LOAD_LIFE;
         end
         ST_LOAD_LIFE: begin
            cmd.ld_life = 1'b1;
            state_in    = ST_CALC_GO;
         end
         ST_LOAD_REC: begin
            cmd.ld_rec = 1'b1;
            rec_in     = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_step = 1'b1;
            if (st.rec_last) state_in = ST_CALC_GO;
         end
         ST_CALC_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = SEL_AVG;
            state_in      = ST_DIV_AVG;
         end
         ST_DIV_AVG: begin
            if (st.div_done) begin
               cmd.cap_a     = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = SEL_E2;
               state_in      = ST_DIV_E2;
            end
         end
         ST_DIV_E2: begin
            if (st.div_done) begin
               cmd.cap_e2 = 1'b1;
               state_in   = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.cap_m2 = 1'b1;
            state_in   = ST_SQRT_GO;
         end
         ST_SQRT_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = ST_SQRT;
         end
         ST_SQRT: begin
            if (st.sqrt_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = SEL_SR;
               state_in      = ST_DIV_SR;
            end
         end
         ST_DIV_SR: begin
            if (st.div_done) begin
               cmd.cap_sr    = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = SEL_VR;
               state_in      = ST_DIV_VR;
            end
         end
         ST_DIV_VR: begin
            cmd.div_sel = SEL_VR;
            if (st.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (st.out_free) begin
               cmd.emit_load = 1'b1;
               state_in      = rec_ff ? ST_IDLE : ST_LOAD_REC;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### src/wss_csr.sv
// Configuration registers behind the APB-style port, with the state clear pulse.
module wss_csr import wss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output logic [31:0]           calc_interval_us,
   output logic [4:0]            bin_count,
   output logic                  enable,
   output logic                  cfg_clear
);

   logic [31:0] interval_ff;
   logic [4:0]  bins_ff;
   logic        enable_ff;
   logic        wr;
   logic [1:0]  index;

   assign wr    = csr_psel && csr_penable && csr_pwrite;
   assign index = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= DEF_INTERVAL_US;
         bins_ff     <= DEF_BIN_COUNT;
         enable_ff   <= 1'b1;
      end else if (wr) begin
         unique case (index)
            REG_INTERVAL:  interval_ff <= csr_pwdata;
            REG_BIN_COUNT: bins_ff     <= csr_pwdata[4:0];
            REG_ENABLE:    enable_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg_clear  = 1'b0;
      csr_prdata = '0;
      unique case (index)
         REG_INTERVAL:  csr_prdata = interval_ff;
         REG_BIN_COUNT: begin
            csr_prdata = {27'd0, bins_ff};
            cfg_clear  = wr;
         end
         REG_ENABLE: begin
            csr_prdata = {31'd0, enable_ff};
            cfg_clear  = wr && !enable_ff && csr_pwdata[0];
         end
         default: ;
      endcase
   end

   assign csr_pready       = 1'b1;
   assign calc_interval_us = interval_ff;
   assign bin_count        = bins_ff;
   assign enable           = enable_ff;

endmodule

### src/windowed_sample_statistics_top.sv
// Top level of the windowed sample statistics block.
//
//  channel  dir  handshake             payload
//  req_     in   req_tvalid/tready     tuser: op; tdata: sample_value, timestamp_us
//  rsp_     out  rsp_tvalid/tready     tuser: window_kind; tlast: last_flag; tdata: stats
//  csr_     in   psel/penable/pready   calc_interval_us @0, bin_count @4, enable @8
//
// Add, clear and ignored items are handled in the idle state, which stays ready for the next item.
// A calculate item that fires yields two result sets, each through the shared bit-serial
// divider (four quotients) and square root unit; the recent set also sweeps the bins in use.
// A calculate item that does not fire passes through the check and decide states back to idle.
// Reset is synchronous; a result waiting on rsp_tready holds the controller at its next emit load.
module windowed_sample_statistics_top import wss_pkg::*; #(
   parameter int MAX_BINS = DEF_MAX_BINS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,   // op
   input  logic [63:0]           req_tdata,   // sample_value, timestamp_us
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_tuser,   // window_kind
   output logic                  rsp_tlast,
   // sample_count, value_sum, value_min, value_max, average_q16, rms_q16,
   // sample_rate_q16, value_rate_q16, duration_us, last_value
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cmd_type     cmd;
   status_type  st;
   logic [31:0] calc_interval_us;
   logic [4:0]  bin_count;
   logic        enable;
   logic        cfg_clear;

   wss_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .calc_interval_us (calc_interval_us),
      .bin_count        (bin_count),
      .enable           (enable),
      .cfg_clear        (cfg_clear)
   );

   wss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .st         (st),
      .cmd        (cmd)
   );

   wss_dp #(
      .MAX_BINS (MAX_BINS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .sample_value     (req_tdata[15:0]),
      .timestamp_us     (req_tdata[63:16]),
      .calc_interval_us (calc_interval_us),
      .bin_count        (bin_count),
      .enable           (enable),
      .cfg_clear        (cfg_clear),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast),
      .rsp_tdata        (rsp_tdata)
   );

endmodule

### dv/wss_stats_checker.sv
// Checker for the windowed sample statistics block: predicts results and compares them.
module wss_stats_checker import wss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [1:0]            req_tuser,   // op
   input  logic [63:0]           req_tdata,   // sample_value, timestamp_us
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  rsp_tuser,   // window_kind
   input  logic                  rsp_tlast,
   // sample_count, value_sum, value_min, value_max, average_q16, rms_q16,
   // sample_rate_q16, value_rate_q16, duration_us, last_value
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    pending
);

   typedef struct {
      logic        kind;
      logic [47:0] cnt;
      logic [63:0] sum;
      logic [15:0] vmin;
      logic [15:0] vmax;
      logic [31:0] avg;
      logic [31:0] rms;
      logic [47:0] srate;
      logic [63:0] vrate;
      logic [47:0] dur;
      logic [15:0] lastv;
      logic        lastf;
   } stats_rec;

   stats_rec    expected_stats[$];

   logic [31:0] interval_us;
   logic [4:0]  bins_reg;
   logic        enabled;

   logic [31:0] w_cnt;
   longint      w_sum;
   logic [63:0] w_sq;
   shortint     w_min, w_max, w_last;
   logic [47:0] t_start;
   bit          started;
   logic [31:0] b_cnt[16];
   longint      b_sum[16];
   logic [63:0] b_sq[16];
   shortint     b_min[16], b_max[16];
   logic [47:0] b_dur[16];
   int          bin_ptr;
   logic [47:0] tot_cnt;
   longint      tot_sum;
   logic [63:0] tot_sq;
   shortint     tot_min, tot_max;
   logic [47:0] tot_dur;

   function automatic longint add_sat_s(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return longint'(s[63:0]);
   endfunction

   function automatic logic [63:0] add_sat_u(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] cap);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, cap}) ? cap : s[63:0];
   endfunction

   // floor(num * mul * 2^sh / den), saturating at 64 bits
   function automatic logic [63:0] fixed_div(logic [63:0] num, logic [63:0] mul, int sh,
                                             logic [63:0] den);
      logic [127:0] p, q;
      p = (128'(num) * 128'(mul)) << sh;
      q = p / 128'(den);
      return (q[127:64] != 0) ? '1 : q[63:0];
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] clamp_signed(bit neg, logic [63:0] mag, logic [63:0] lim);
      if (neg) begin
         if (mag > lim + 1) mag = lim + 1;
         return 64'd0 - mag;
      end
      return (mag > lim) ? lim : mag;
   endfunction

   function automatic stats_rec summarize(logic kind, logic [47:0] cnt, longint sum,
                                          logic [63:0] sq, shortint vmin, shortint vmax,
                                          logic [47:0] dur);
      stats_rec r;
      bit neg;
      logic [63:0] mag, a, e2, m, m2, sr;
      neg = sum < 0;
      mag = neg ? 64'd0 - 64'(sum) : 64'(sum);
      r.kind = kind;
      r.lastf = kind;
      r.cnt = cnt;
      r.sum = 64'(sum);
      r.vmin = 16'(vmin);
      r.vmax = 16'(vmax);
      r.dur = dur;
      r.lastv = 16'(w_last);
      r.avg = 0;
      r.rms = 0;
      r.srate = 0;
      r.vrate = 0;
      if (cnt != 0) begin
         a = fixed_div(mag, 1, 16, 64'(cnt));
         e2 = fixed_div(sq, 1, 32, 64'(cnt));
         m = (a > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : a;
         m2 = m * m;
         r.avg = 32'(clamp_signed(neg, a, 64'h7FFF_FFFF));
         r.rms = 32'(int_sqrt(e2 > m2 ? e2 - m2 : 64'd0));
      end
      if (dur != 0) begin
         sr = fixed_div(64'(cnt), 64'd1000000, 16, 64'(dur));
         r.srate = (sr > 64'(CNT48_MAX)) ? CNT48_MAX : sr[47:0];
         r.vrate = clamp_signed(neg, fixed_div(mag, 64'd1000000, 16, 64'(dur)),
                                64'h7FFF_FFFF_FFFF_FFFF);
      end
      return r;
   endfunction

   task automatic clear_all();
      w_cnt = 0; w_sum = 0; w_sq = 0;
      w_min = 16'sh7FFF; w_max = -16'sh8000; w_last = 0;
      t_start = 0; started = 0;
      for (int i = 0; i < 16; i++) begin
         b_cnt[i] = 0; b_sum[i] = 0; b_sq[i] = 0;
         b_min[i] = 16'sh7FFF; b_max[i] = -16'sh8000; b_dur[i] = 0;
      end
      bin_ptr = 0;
      tot_cnt = 0; tot_sum = 0; tot_sq = 0;
      tot_min = 16'sh7FFF; tot_max = -16'sh8000; tot_dur = 0;
   endtask

   task automatic apply_item(logic [1:0] op, shortint v, logic [47:0] t);
      logic [47:0] dur;
      int nb, p;
      logic [47:0] rc, rd;
      longint rs;
      logic [63:0] rq;
      shortint rmin, rmax;
      if (op == OP_CLEAR) begin
         clear_all();
         return;
      end
      if (!(op == OP_ADD || op == OP_CALC) || !enabled) return;
      if (op == OP_ADD) begin
         if (!started) begin
            t_start = t;
            started = 1;
         end
         if (w_cnt != 32'hFFFF_FFFF) w_cnt++;
         w_sum = add_sat_s(w_sum, longint'(v));
         w_sq = add_sat_u(w_sq, 64'(longint'(v) * longint'(v)), '1);
         if (v < w_min) w_min = v;
         if (v > w_max) w_max = v;
         w_last = v;
         return;
      end
      if (!started || t < t_start) return;
      dur = t - t_start;
      if (dur < 48'(interval_us)) return;
      t_start = t;
      tot_cnt = 48'(add_sat_u(64'(tot_cnt), 64'(w_cnt), 64'(CNT48_MAX)));
      tot_sum = add_sat_s(tot_sum, w_sum);
      tot_sq = add_sat_u(tot_sq, w_sq, '1);
      if (w_min < tot_min) tot_min = w_min;
      if (w_max > tot_max) tot_max = w_max;
      tot_dur = 48'(add_sat_u(64'(tot_dur), 64'(dur), 64'(CNT48_MAX)));
      nb = (bins_reg == 0) ? 1 : (bins_reg > 16) ? 16 : int'(bins_reg);
      p = (bin_ptr < nb) ? bin_ptr : 0;
      b_cnt[p] = w_cnt; b_sum[p] = w_sum; b_sq[p] = w_sq;
      b_min[p] = w_min; b_max[p] = w_max; b_dur[p] = dur;
      rc = 0; rs = 0; rq = 0; rmin = 16'sh7FFF; rmax = -16'sh8000; rd = 0;
      for (int i = 0; i < nb; i++) begin
         rc = 48'(add_sat_u(64'(rc), 64'(b_cnt[i]), 64'(CNT48_MAX)));
         rs = add_sat_s(rs, b_sum[i]);
         rq = add_sat_u(rq, b_sq[i], '1);
         if (b_min[i] < rmin) rmin = b_min[i];
         if (b_max[i] > rmax) rmax = b_max[i];
         rd = 48'(add_sat_u(64'(rd), 64'(b_dur[i]), 64'(CNT48_MAX)));
      end
      bin_ptr = (p + 1 >= nb) ? 0 : p + 1;
      w_cnt = 0; w_sum = 0; w_sq = 0; w_min = 16'sh7FFF; w_max = -16'sh8000;
      expected_stats.push_back(summarize(1'b0, tot_cnt, tot_sum, tot_sq, tot_min, tot_max,
                                         tot_dur));
      expected_stats.push_back(summarize(1'b1, rc, rs, rq, rmin, rmax, rd));
   endtask

   task automatic cmp(string nm, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t mismatch %s: expected %h actual %h", $time, nm, exp_v, act_v);
         fail_count++;
      end
   endtask

   task automatic check_result();
      stats_rec e;
      if (expected_stats.size() == 0) begin
         $display("%0t unexpected result: expected none actual %h", $time, rsp_tdata);
         fail_count++;
         return;
      end
      e = expected_stats.pop_front();
      cmp("window_kind", 64'(e.kind), 64'(rsp_tuser));
      cmp("last_flag", 64'(e.lastf), 64'(rsp_tlast));
      cmp("sample_count", 64'(e.cnt), 64'(rsp_tdata[47:0]));
      cmp("value_sum", e.sum, rsp_tdata[111:48]);
      cmp("value_min", 64'(e.vmin), 64'(rsp_tdata[127:112]));
      cmp("value_max", 64'(e.vmax), 64'(rsp_tdata[143:128]));
      cmp("average_q16", 64'(e.avg), 64'(rsp_tdata[175:144]));
      cmp("rms_q16", 64'(e.rms), 64'(rsp_tdata[207:176]));
      cmp("sample_rate_q16", 64'(e.srate), 64'(rsp_tdata[255:208]));
      cmp("value_rate_q16", e.vrate, rsp_tdata[319:256]);
      cmp("duration_us", 64'(e.dur), 64'(rsp_tdata[367:320]));
      cmp("last_value", 64'(e.lastv), 64'(rsp_tdata[383:368]));
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         interval_us = DEF_INTERVAL_US;
         bins_reg = DEF_BIN_COUNT;
         enabled = 1;
         clear_all();
         expected_stats.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr >> 2))
               REG_INTERVAL: interval_us = csr_pwdata;
               REG_BIN_COUNT: begin
                  bins_reg = csr_pwdata[4:0];
                  clear_all();
               end
               REG_ENABLE: begin
                  if (!enabled && csr_pwdata[0]) clear_all();
                  enabled = csr_pwdata[0];
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            apply_item(req_tuser, shortint'(req_tdata[15:0]), req_tdata[63:16]);
      end
      pending = expected_stats.size();
   end

endmodule

### dv/tb_windowed_sample_statistics_top.sv
// Testbench top for the windowed sample statistics block: stimulus, pacing and verdict.
module tb_windowed_sample_statistics_top;
   import wss_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 10000000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [1:0]            req_tuser = OP_ADD;
   logic [63:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 0;
   logic                  csr_penable = 0;
   logic                  csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int          fail_count;
   int          pending;
   int          cycles = 0;
   bit          idling = 1;
   int          hold_off = 0;
   logic [47:0] now_us = 0;
   logic [31:0] cur_interval;

   windowed_sample_statistics_top u_dut (.*);

   wss_stats_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tuser, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tuser, .rsp_tlast, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .fail_count, .pending
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_windowed_sample_statistics_top: done, errors");
         $finish;
      end
   end

   // result side pacing
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            n = hold_off;
            rsp_tready = 0;
            repeat (n) @(negedge clock);
            hold_off = 0;
         end else if (idling && $urandom_range(0, 3) == 0) begin
            rsp_tready = 0;
            repeat ($urandom_range(1, 19) - 1) @(negedge clock);
         end else begin
            rsp_tready = 1;
            repeat ($urandom_range(1, 30) - 1) @(negedge clock);
         end
      end
   end

   task automatic send_item(logic [1:0] op, logic [15:0] v, logic [47:0] t);
      @(negedge clock);
      if (idling && $urandom_range(0, 7) == 0) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser = op;
      req_tdata = {t, v};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 0;
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      drain();
      @(negedge clock);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_paddr = CSR_ADDR_W'(idx) << 2;
      csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1;
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      if (idx == REG_INTERVAL) cur_interval = val;
   endtask

   task automatic random_item();
      int r;
      logic [15:0] v;
      logic [47:0] step;
      r = $urandom_range(0, 99);
      step = (cur_interval > 32'd40) ? 48'd40 : 48'(cur_interval);
      if (r < 72) begin
         case ($urandom_range(0, 9))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            default: v = 16'($urandom);
         endcase
         now_us = now_us + $urandom_range(0, 3);
         send_item(OP_ADD, v, now_us);
      end else if (r < 90) begin
         now_us = now_us + $urandom_range(0, 2 * int'(step) + 1);
         if (cur_interval == 32'hFFFF_FFFF && $urandom_range(0, 1) == 0)
            now_us = now_us + 48'h1_0000_0000;
         send_item(OP_CALC, 16'($urandom), now_us);
      end else if (r < 93) begin
         send_item(OP_CLEAR, 16'($urandom), now_us);
      end else if (r < 95) begin
         send_item(OP_UNUSED, 16'($urandom), now_us);
      end else if (r < 97) begin
         send_item(OP_CALC, 16'($urandom), now_us - $urandom_range(1, 10));
      end else begin
         now_us = {16'($urandom), 32'($urandom)};
         send_item(OP_ADD, 16'($urandom), now_us);
      end
   endtask

   initial begin
      logic [31:0] ivals[8];
      logic [4:0]  nbins[8];
      ivals = '{32'd0, 32'd1, 32'd5, 32'd10, 32'd3, 32'd20, 32'hFFFF_FFFF, 32'd2};
      nbins = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd8, 5'd2, 5'd16};
      cur_interval = DEF_INTERVAL_US;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // defaults: long interval, full window
      send_item(OP_CALC, 16'd0, 48'd100);
      send_item(OP_ADD, 16'h7FFF, 48'd0);
      send_item(OP_ADD, 16'h8000, 48'd10);
      send_item(OP_ADD, 16'd0, 48'd20);
      send_item(OP_ADD, 16'hFFFF, 48'd30);
      send_item(OP_UNUSED, 16'h5555, 48'd40);
      send_item(OP_CALC, 16'd0, 48'd999999);
      send_item(OP_CALC, 16'd0, 48'd1000000);
      send_item(OP_CALC, 16'd0, 48'd1500000);
      send_item(OP_CALC, 16'd0, 48'd2000000);

      // zero interval, single bin: zero duration, empty window, time going back
      csr_write(REG_INTERVAL, 32'd0);
      csr_write(REG_BIN_COUNT, 32'd1);
      send_item(OP_ADD, 16'd5, 48'd500);
      send_item(OP_CALC, 16'd0, 48'd500);
      send_item(OP_CALC, 16'd0, 48'd500);
      send_item(OP_CALC, 16'd0, 48'd499);
      send_item(OP_CLEAR, 16'd0, 48'd0);
      send_item(OP_ADD, 16'h1234, 48'hFFFF_FFFF_FFFF);
      send_item(OP_CALC, 16'd0, 48'hFFFF_FFFF_FFFF);

      // disabled block ignores adds and calcs; clear still works
      csr_write(REG_ENABLE, 32'd0);
      send_item(OP_ADD, 16'd7, 48'd10);
      send_item(OP_CALC, 16'd0, 48'd20);
      send_item(OP_CLEAR, 16'd0, 48'd30);
      csr_write(REG_ENABLE, 32'd1);
      send_item(OP_CALC, 16'd0, 48'd40);

      for (int ph = 0; ph < 8; ph++) begin
         csr_write(REG_INTERVAL, ivals[ph]);
         csr_write(REG_BIN_COUNT, 32'(nbins[ph]));
         if (ph == 4) begin
            csr_write(REG_ENABLE, 32'd0);
            csr_write(REG_ENABLE, 32'd1);
         end
         if (ph == 7) idling = 0;
         now_us = 48'($urandom_range(0, 1000));
         for (int k = 0; k < 210; k++) begin
            if (ph == 2 && k == 60) hold_off = 4000;
            if (ph == 5 && k == 100) begin
               @(negedge clock);
               req_tvalid = 0;
               while (pending != 0) @(posedge clock);
            end
            random_item();
         end
      end

      drain();
      repeat (1000) @(posedge clock);
      if (fail_count == 0)
         $display("tb_windowed_sample_statistics_top: done, clean");
      else
         $display("tb_windowed_sample_statistics_top: done, errors");
      $finish;
   end

endmodule
